// ----- rtl/core/tarc_pkg.sv -----
`timescale 1ns / 1ps

package tarc_pkg;

    // configuration word width and tick counter width
    localparam int CFG_W    = 16;
    localparam int TICK_W   = 16;
    localparam int CMP_W    = (TICK_W > CFG_W) ? TICK_W : CFG_W;
    localparam int WAIT_W   = 16;
    localparam int BIT_W    = 5;
    localparam int SAMPLE_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] CNT_MAX = {TICK_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // control bytes sent ahead of each conversion
    localparam logic [7:0] CMD_Y = 8'h94;
    localparam logic [7:0] CMD_X = 8'hD0;

    // pulse numbering within one read
    localparam logic [BIT_W-1:0] PULSE_BUSY       = BIT_W'(8);
    localparam logic [BIT_W-1:0] PULSE_DATA_FIRST = BIT_W'(9);
    localparam logic [BIT_W-1:0] PULSE_DATA_LAST  = BIT_W'(20);
    localparam logic [BIT_W-1:0] PULSE_TOTAL      = BIT_W'(24);
    localparam logic [BIT_W-1:0] CMD_BITS         = BIT_W'(8);

    localparam logic [CFG_W-1:0] HALF_RESET    = CFG_W'(1000);
    localparam logic [CFG_W-1:0] SETUP_RESET   = CFG_W'(1000);
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(0);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SETUP   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(2);

    typedef struct packed {
        logic [CFG_W-1:0] half_period_ticks;
        logic [CFG_W-1:0] select_setup_ticks;
        logic [CFG_W-1:0] busy_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic pen_irq_n;
        logic busy_level;
        logic data_in_level;
    } tick_t;

    typedef struct packed {
        logic                select_n;
        logic                serial_clock;
        logic                data_out;
        logic [SAMPLE_W-1:0] x_value;
        logic [SAMPLE_W-1:0] y_value;
        logic                pair_valid;
        logic                timeout_error;
    } result_t;

    // limit a register value to what the tick counter can hold
    function automatic logic [TICK_W-1:0] clip_cnt(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext > CMP_W'(CNT_MAX))
            return CNT_MAX;
        else
            return TICK_W'(ext);
    endfunction

    function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] v);
        if (v == CNT_MAX)
            return CNT_MAX;
        else
            return v + TICK_W'(1);
    endfunction

    // command bit k of the control byte for the selected axis, zero past the byte
    function automatic logic cmd_bit(input logic axis, input logic [BIT_W-1:0] k);
        logic [7:0] cmd;
        cmd = axis ? CMD_X : CMD_Y;
        if (k >= CMD_BITS)
            return 1'b0;
        else
            return cmd[3'(3'd7 - k[2:0])];
    endfunction

endpackage

// ----- rtl/core/tarc_in_if.sv -----
`timescale 1ns / 1ps

interface tarc_in_if;
    logic valid;
    logic ready;
    logic pen_irq_n;
    logic busy_level;
    logic data_in_level;

    modport source (output valid, pen_irq_n, busy_level, data_in_level, input ready);
    modport sink (input valid, pen_irq_n, busy_level, data_in_level, output ready);
endinterface

// ----- rtl/core/tarc_out_if.sv -----
`timescale 1ns / 1ps

interface tarc_out_if
    import tarc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                select_n;
    logic                serial_clock;
    logic                data_out;
    logic [SAMPLE_W-1:0] x_value;
    logic [SAMPLE_W-1:0] y_value;
    logic                pair_valid;
    logic                timeout_error;

    modport source (
        output valid, select_n, serial_clock, data_out, x_value, y_value,
               pair_valid, timeout_error,
        input  ready
    );
    modport sink (
        input  valid, select_n, serial_clock, data_out, x_value, y_value,
               pair_valid, timeout_error,
        output ready
    );
endinterface

// ----- rtl/core/tarc_cfg_if.sv -----
`timescale 1ns / 1ps

interface tarc_cfg_if
    import tarc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/touch_adc_serial_reader_unit.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// in_ch     in   valid / ready    pen_irq_n, busy_level, data_in_level (one tick of pins)
// out_ch    out  valid / ready    select_n, serial_clock, data_out, x_value, y_value,
//                                 pair_valid, timeout_error (one result per tick)
// cfg       in   valid / ready    index (0 half period, 1 select setup, 2 busy timeout),
//                                 data (16 bits)
//
// one tick per clock sustained while the output side accepts; a tick passes from input transfer
// to result through the input register, one pass of the sequencer logic and the result register
// reset: idle, Y read next, coordinates zero, half period and setup 1000, no timeout
// a stalled output holds its result while one more tick waits in the input register;
// further ticks are held off until the output side takes a transfer

module touch_adc_serial_reader_unit
    import tarc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tarc_in_if.sink     in_ch,
    tarc_out_if.source  out_ch,
    tarc_cfg_if.sink    cfg
);

    cfg_t    regs;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    // tick moves into the sequencer when the result register is free or draining
    assign advance     = tick_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !tick_valid_reg || advance;

    tarc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tarc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .tick    (tick_reg),
        .regs    (regs),
        .res     (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (in_ch.ready)
            tick_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            tick_reg.pen_irq_n     <= in_ch.pen_irq_n;
            tick_reg.busy_level    <= in_ch.busy_level;
            tick_reg.data_in_level <= in_ch.data_in_level;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.select_n      = res_reg.select_n;
    assign out_ch.serial_clock  = res_reg.serial_clock;
    assign out_ch.data_out      = res_reg.data_out;
    assign out_ch.x_value       = res_reg.x_value;
    assign out_ch.y_value       = res_reg.y_value;
    assign out_ch.pair_valid    = res_reg.pair_valid;
    assign out_ch.timeout_error = res_reg.timeout_error;

endmodule

// ----- rtl/core/tarc_cfg_regs.sv -----
`timescale 1ns / 1ps

module tarc_cfg_regs
    import tarc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tarc_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.half_period_ticks  <= HALF_RESET;
            regs_reg.select_setup_ticks <= SETUP_RESET;
            regs_reg.busy_timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            // unknown indexes are dropped
            case (cfg.index)
                REG_HALF:    regs_reg.half_period_ticks  <= cfg.data;
                REG_SETUP:   regs_reg.select_setup_ticks <= cfg.data;
                REG_TIMEOUT: regs_reg.busy_timeout_ticks <= cfg.data;
                default:     ;
            endcase
        end
    end

endmodule

// ----- rtl/core/tarc_seq.sv -----
`timescale 1ns / 1ps

module tarc_seq
    import tarc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  tick_t   tick,
    input  cfg_t    regs,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_BUSY  = 3'd4,
        PH_GAP   = 3'd5
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BIT_W-1:0]    bit_count_reg, bit_count_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [WAIT_W-1:0]   wait_count_reg, wait_count_next;
    logic [SAMPLE_W-1:0] shift_reg, shift_next;
    logic                axis_sel_reg, axis_sel_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [SAMPLE_W-1:0] y_reg, y_next;

    logic [TICK_W-1:0]   half;
    logic [TICK_W-1:0]   tick_up;
    logic [WAIT_W-1:0]   wait_up;
    logic [BIT_W-1:0]    pulse_next;
    logic                pv;
    logic                te;
    logic                dout;

    always_comb
    begin
        half = clip_cnt(regs.half_period_ticks);
        if (half == '0)
            half = TICK_W'(1);
        tick_up    = tick_inc(tick_count_reg);
        wait_up    = (wait_count_reg == WAIT_MAX) ? WAIT_MAX : wait_count_reg + WAIT_W'(1);
        pulse_next = bit_count_reg + BIT_W'(1);

        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        wait_count_next = wait_count_reg;
        shift_next      = shift_reg;
        axis_sel_next   = axis_sel_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        pv              = 1'b0;
        te              = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (!tick.pen_irq_n)
                begin
                    axis_sel_next   = 1'b0;
                    phase_next      = PH_SETUP;
                    tick_count_next = '0;
                    bit_count_next  = '0;
                    wait_count_next = '0;
                    shift_next      = '0;
                end
            end
            PH_GAP:
            begin
                axis_sel_next   = 1'b1;
                phase_next      = PH_SETUP;
                tick_count_next = '0;
                bit_count_next  = '0;
                wait_count_next = '0;
                shift_next      = '0;
            end
            PH_SETUP:
            begin
                tick_count_next = tick_up;
                if (tick_up >= clip_cnt(regs.select_setup_ticks))
                begin
                    phase_next      = PH_HIGH;
                    tick_count_next = '0;
                end
            end
            PH_HIGH:
            begin
                tick_count_next = tick_up;
                if (tick_up >= half)
                begin
                    phase_next      = PH_LOW;
                    tick_count_next = '0;
                end
            end
            PH_LOW:
            begin
                tick_count_next = tick_up;
                if (tick_up >= half)
                begin
                    tick_count_next = '0;
                    if (pulse_next == PULSE_BUSY)
                    begin
                        bit_count_next  = PULSE_BUSY;
                        wait_count_next = '0;
                        phase_next      = PH_BUSY;
                    end
                    else if (pulse_next >= PULSE_TOTAL)
                    begin
                        bit_count_next = '0;
                        if (!axis_sel_reg)
                        begin
                            y_next        = shift_reg;
                            axis_sel_next = 1'b1;
                            phase_next    = PH_GAP;
                        end
                        else
                        begin
                            x_next        = shift_reg;
                            axis_sel_next = 1'b0;
                            pv            = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    else
                    begin
                        bit_count_next = pulse_next;
                        if (pulse_next >= PULSE_DATA_FIRST && pulse_next <= PULSE_DATA_LAST)
                            shift_next = {shift_reg[SAMPLE_W-2:0], tick.data_in_level};
                        phase_next = PH_HIGH;
                    end
                end
            end
            PH_BUSY:
            begin
                if (tick.busy_level)
                begin
                    phase_next      = PH_HIGH;
                    tick_count_next = '0;
                end
                else if (regs.busy_timeout_ticks != '0)
                begin
                    wait_count_next = wait_up;
                    if (wait_up >= regs.busy_timeout_ticks)
                    begin
                        te              = 1'b1;
                        phase_next      = PH_IDLE;
                        axis_sel_next   = 1'b0;
                        bit_count_next  = '0;
                        tick_count_next = '0;
                        wait_count_next = '0;
                    end
                end
            end
            default:
            begin
                phase_next      = PH_IDLE;
                bit_count_next  = '0;
                tick_count_next = '0;
                wait_count_next = '0;
            end
        endcase

        // data out follows the state after the tick
        case (phase_next)
            PH_SETUP: dout = cmd_bit(axis_sel_next, '0);
            PH_HIGH:  dout = cmd_bit(axis_sel_next, bit_count_next);
            PH_LOW:   dout = cmd_bit(axis_sel_next, bit_count_next + BIT_W'(1));
            default:  dout = 1'b0;
        endcase

        res.select_n      = (phase_next == PH_IDLE) || (phase_next == PH_GAP);
        res.serial_clock  = (phase_next == PH_HIGH);
        res.data_out      = dout;
        res.x_value       = x_next;
        res.y_value       = y_next;
        res.pair_valid    = pv;
        res.timeout_error = te;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            tick_count_reg <= '0;
            wait_count_reg <= '0;
            shift_reg      <= '0;
            axis_sel_reg   <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            wait_count_reg <= wait_count_next;
            shift_reg      <= shift_next;
            axis_sel_reg   <= axis_sel_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
        end
    end

endmodule
